@@ sv/lpr_pkg.sv @@
package lpr_pkg;

   localparam int WAIT_COUNT_WIDTH = 16;
   localparam int TIMEOUT_WIDTH = 16;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd1000;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_TICK = 1'b1
   } item_kind_type;

   typedef enum logic [2:0] {
      ST_PAYLOAD      = 3'd0,
      ST_OK           = 3'd1,
      ST_HDR_TIMEOUT  = 3'd2,
      ST_DATA_TIMEOUT = 3'd3,
      ST_CSUM_ERROR   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      PH_IFACE = 4'b0001,
      PH_LEN   = 4'b0010,
      PH_DATA  = 4'b0100,
      PH_CSUM  = 4'b1000
   } phase_type;

   typedef struct packed {
      item_kind_type req_type;
      logic [7:0]    rx_byte;
   } req_item_type;

   typedef struct packed {
      status_type status;
      logic [7:0] interface_id;
      logic [7:0] payload_len;
      logic [7:0] payload_byte;
      logic [7:0] byte_index;
      logic [8:0] packet_size;
   } rsp_item_type;

endpackage

@@ sv/lpr_in_reg.sv @@
module lpr_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lpr_pkg::req_item_type req_item,
   output logic                  item_valid,
   input  logic                  item_take,
   output lpr_pkg::req_item_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   lpr_pkg::req_item_type item_ff;

   assign req_ready  = !valid_ff || item_take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

@@ sv/lpr_frame.sv @@
module lpr_frame #(
   parameter int WAIT_COUNT_WIDTH = lpr_pkg::WAIT_COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [lpr_pkg::TIMEOUT_WIDTH-1:0]   csr_value,
   input  logic                                item_valid,
   output logic                                item_take,
   input  lpr_pkg::req_item_type               item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lpr_pkg::rsp_item_type               rsp
);

   localparam int CmpWidth = (WAIT_COUNT_WIDTH > lpr_pkg::TIMEOUT_WIDTH) ?
                             WAIT_COUNT_WIDTH : lpr_pkg::TIMEOUT_WIDTH;

   logic [lpr_pkg::TIMEOUT_WIDTH-1:0] timeout_ff;
   lpr_pkg::phase_type                phase_ff, phase_in;
   logic [7:0]                        iface_ff, iface_in;
   logic [7:0]                        len_ff, len_in;
   logic [7:0]                        count_ff, count_in;
   logic [7:0]                        sum_ff, sum_in;
   logic [WAIT_COUNT_WIDTH-1:0]       wait_ff, wait_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   lpr_pkg::rsp_item_type             rsp_ff;
   lpr_pkg::rsp_item_type             res;
   logic                              has_res;
   logic [WAIT_COUNT_WIDTH-1:0]       wait_next;
   logic [7:0]                        count_next;
   logic                              restart;

   assign item_take = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign wait_next  = (wait_ff == '1) ? wait_ff : wait_ff + 1'b1;
   assign count_next = count_ff + 8'd1;

   always_comb begin
      phase_in = phase_ff;
      iface_in = iface_ff;
      len_in   = len_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      wait_in  = wait_ff;
      has_res  = 1'b0;
      restart  = 1'b0;
      res.status       = lpr_pkg::ST_PAYLOAD;
      res.interface_id = iface_ff;
      res.payload_len  = len_ff;
      res.payload_byte = 8'd0;
      res.byte_index   = 8'd0;
      res.packet_size  = 9'd0;
      if (item.req_type == lpr_pkg::KIND_TICK) begin
         wait_in = wait_next;
         if (CmpWidth'(wait_next) >= CmpWidth'(timeout_ff)) begin
            has_res = 1'b1;
            restart = 1'b1;
            res.status = (phase_ff == lpr_pkg::PH_IFACE || phase_ff == lpr_pkg::PH_LEN) ?
                         lpr_pkg::ST_HDR_TIMEOUT : lpr_pkg::ST_DATA_TIMEOUT;
         end
      end else begin
         unique case (phase_ff)
            lpr_pkg::PH_IFACE: begin
               iface_in = item.rx_byte;
               sum_in   = item.rx_byte;
               phase_in = lpr_pkg::PH_LEN;
            end
            lpr_pkg::PH_LEN: begin
               len_in   = item.rx_byte;
               sum_in   = sum_ff + item.rx_byte;
               count_in = 8'd0;
               phase_in = (item.rx_byte == 8'd0) ? lpr_pkg::PH_CSUM : lpr_pkg::PH_DATA;
            end
            lpr_pkg::PH_DATA: begin
               has_res          = 1'b1;
               res.payload_byte = item.rx_byte;
               res.byte_index   = count_ff;
               sum_in           = sum_ff + item.rx_byte;
               count_in         = count_next;
               if (count_next >= len_ff) begin
                  phase_in = lpr_pkg::PH_CSUM;
               end
            end
            lpr_pkg::PH_CSUM: begin
               has_res = 1'b1;
               restart = 1'b1;
               if (item.rx_byte == sum_ff) begin
                  res.status      = lpr_pkg::ST_OK;
                  res.packet_size = {1'b0, len_ff} + 9'd3;
               end else begin
                  res.status = lpr_pkg::ST_CSUM_ERROR;
               end
            end
            default: begin
               restart = 1'b1;
            end
         endcase
      end
      if (restart) begin
         phase_in = lpr_pkg::PH_IFACE;
         iface_in = 8'd0;
         len_in   = 8'd0;
         count_in = 8'd0;
         sum_in   = 8'd0;
         wait_in  = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_take && has_res) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= lpr_pkg::TIMEOUT_RESET;
         phase_ff     <= lpr_pkg::PH_IFACE;
         iface_ff     <= 8'd0;
         len_ff       <= 8'd0;
         count_ff     <= 8'd0;
         sum_ff       <= 8'd0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            timeout_ff <= csr_value;
         end
         if (item_take) begin
            phase_ff <= phase_in;
            iface_ff <= iface_in;
            len_ff   <= len_in;
            count_ff <= count_in;
            sum_ff   <= sum_in;
            wait_ff  <= wait_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && has_res) begin
         rsp_ff <= res;
      end
   end

endmodule

@@ sv/length_prefixed_packet_receiver.sv @@
// Length-prefixed packet receiver with additive checksum.
// req channel: one item per byte or per waiting tick. tuser = 0 marks a
// received byte in tdata, tuser = 1 marks one elapsed tick (tdata ignored).
// Frames are interface byte, length byte, payload bytes, checksum byte; the
// checksum is the 8-bit sum of all earlier bytes of the frame.
// rsp channel: tuser is the status (payload byte, packet ok, header timeout,
// data timeout, checksum error); tdata carries interface id, length, payload
// byte and its index, and the total packet size on packet ok.
// csr channel: writes the timeout limit in ticks; always ready. The user must
// keep it written only while the block is idle; the block does not enforce it.
// Throughput is one item per cycle unless a full result register is held by
// rsp_tready; each item passes an input register and the frame state update,
// and a result that it yields is written into the result register.
// Reset clears the frame state, restores a limit of 1000 ticks and empties
// both registers. When rsp_tready is low the result register holds and the
// input register fills, after which req_tready drops until the result moves.
module length_prefixed_packet_receiver #(
   parameter int WAIT_COUNT_WIDTH = lpr_pkg::WAIT_COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // rx_byte
   input  logic                                req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // interface_id, payload_len, payload_byte, byte_index, packet_size, pad
   output logic [47:0]                         rsp_tdata,
   output logic [2:0]                          rsp_tuser,  // status
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lpr_pkg::TIMEOUT_WIDTH-1:0]   csr_data
);

   lpr_pkg::req_item_type req_item;
   lpr_pkg::req_item_type item;
   lpr_pkg::rsp_item_type rsp;
   logic                  item_valid;
   logic                  item_take;

   assign req_item.req_type = lpr_pkg::item_kind_type'(req_tuser);
   assign req_item.rx_byte  = req_tdata;
   assign csr_ready         = 1'b1;

   lpr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   lpr_frame #(
      .WAIT_COUNT_WIDTH (WAIT_COUNT_WIDTH)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_value  (csr_data),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tuser = rsp.status;
   assign rsp_tdata = {7'd0, rsp.packet_size, rsp.byte_index, rsp.payload_byte,
                       rsp.payload_len, rsp.interface_id};

endmodule

@@ tb/sv/tb.sv @@
module tb;

   localparam int IDLE_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [lpr_pkg::TIMEOUT_WIDTH-1:0] csr_data = '0;

   length_prefixed_packet_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // frame tracking state
   logic [lpr_pkg::TIMEOUT_WIDTH-1:0]    limit_ticks = lpr_pkg::TIMEOUT_RESET;
   lpr_pkg::phase_type                   frame_phase = lpr_pkg::PH_IFACE;
   logic [7:0]                           frame_iface = '0;
   logic [7:0]                           frame_len = '0;
   logic [7:0]                           data_count = '0;
   logic [7:0]                           csum_acc = '0;
   logic [lpr_pkg::WAIT_COUNT_WIDTH-1:0] ticks_seen = '0;

   lpr_pkg::req_item_type tx_items[$];
   lpr_pkg::rsp_item_type frame_results_q[$];
   int n_queued = 0;
   int n_accepted = 0;
   int n_errors = 0;
   int idle_cycles = 0;
   logic req_taken = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   int stall_mode = 0;

   task report_mismatch(input string msg);
      n_errors++;
      if (n_errors <= 100) $display("ERROR at %0t: %s", $time, msg);
   endtask

   task clear_frame;
      frame_phase = lpr_pkg::PH_IFACE;
      frame_iface = '0;
      frame_len = '0;
      data_count = '0;
      csum_acc = '0;
      ticks_seen = '0;
   endtask

   task add_result(input lpr_pkg::status_type st, input logic [7:0] pbyte,
                   input logic [7:0] idx, input logic [8:0] size);
      lpr_pkg::rsp_item_type r;
      r.status = st;
      r.interface_id = frame_iface;
      r.payload_len = frame_len;
      r.payload_byte = pbyte;
      r.byte_index = idx;
      r.packet_size = size;
      frame_results_q.push_back(r);
   endtask

   task track_frame(input lpr_pkg::req_item_type it);
      logic [7:0] b;
      b = it.rx_byte;
      if (it.req_type == lpr_pkg::KIND_TICK) begin
         if (ticks_seen != '1) ticks_seen++;
         if (ticks_seen >= limit_ticks) begin
            add_result((frame_phase == lpr_pkg::PH_IFACE || frame_phase == lpr_pkg::PH_LEN) ?
                       lpr_pkg::ST_HDR_TIMEOUT : lpr_pkg::ST_DATA_TIMEOUT,
                       8'd0, 8'd0, 9'd0);
            clear_frame();
         end
      end else begin
         case (frame_phase)
            lpr_pkg::PH_IFACE: begin
               frame_iface = b;
               csum_acc = b;
               frame_phase = lpr_pkg::PH_LEN;
            end
            lpr_pkg::PH_LEN: begin
               frame_len = b;
               csum_acc = csum_acc + b;
               data_count = '0;
               frame_phase = (b == 8'd0) ? lpr_pkg::PH_CSUM : lpr_pkg::PH_DATA;
            end
            lpr_pkg::PH_DATA: begin
               add_result(lpr_pkg::ST_PAYLOAD, b, data_count, 9'd0);
               csum_acc = csum_acc + b;
               data_count = data_count + 8'd1;
               if (data_count >= frame_len) frame_phase = lpr_pkg::PH_CSUM;
            end
            default: begin
               if (b == csum_acc)
                  add_result(lpr_pkg::ST_OK, 8'd0, 8'd0, 9'(frame_len) + 9'd3);
               else add_result(lpr_pkg::ST_CSUM_ERROR, 8'd0, 8'd0, 9'd0);
               clear_frame();
            end
         endcase
      end
   endtask

   // acceptance, prediction, result check, watchdog
   always @(posedge clock) begin
      lpr_pkg::req_item_type in_item;
      lpr_pkg::rsp_item_type got;
      lpr_pkg::rsp_item_type want;
      logic fired;
      fired = 1'b0;
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            in_item.req_type = lpr_pkg::item_kind_type'(req_tuser);
            in_item.rx_byte = req_tdata;
            track_frame(in_item);
            n_accepted++;
            fired = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            fired = 1'b1;
            got.status = lpr_pkg::status_type'(rsp_tuser);
            got.interface_id = rsp_tdata[7:0];
            got.payload_len = rsp_tdata[15:8];
            got.payload_byte = rsp_tdata[23:16];
            got.byte_index = rsp_tdata[31:24];
            got.packet_size = rsp_tdata[40:32];
            if (frame_results_q.size() == 0) begin
               report_mismatch($sformatf("result with none pending: status %0d", rsp_tuser));
            end else begin
               want = frame_results_q.pop_front();
               if (got !== want)
                  report_mismatch($sformatf(
                     "got %0d %h %h %h %0d %0d exp %0d %h %h %h %0d %0d",
                     rsp_tuser, got.interface_id, got.payload_len, got.payload_byte,
                     got.byte_index, got.packet_size,
                     want.status, want.interface_id, want.payload_len, want.payload_byte,
                     want.byte_index, want.packet_size));
            end
         end
         if (csr_valid && csr_ready) fired = 1'b1;
         if (fired) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // sender: bursts and gaps
   always @(negedge clock) begin
      lpr_pkg::req_item_type nxt;
      if (!reset && !(req_tvalid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (tx_items.size() > 0) begin
            nxt = tx_items.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= nxt.req_type;
            req_tdata <= nxt.rx_byte;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 300);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task push_item(input lpr_pkg::item_kind_type kind, input logic [7:0] b);
      lpr_pkg::req_item_type it;
      it.req_type = kind;
      it.rx_byte = b;
      tx_items.push_back(it);
      n_queued++;
   endtask

   task push_byte(input logic [7:0] b);
      push_item(lpr_pkg::KIND_BYTE, b);
   endtask

   task push_ticks(input int n);
      for (int i = 0; i < n; i++) push_item(lpr_pkg::KIND_TICK, 8'($urandom));
   endtask

   task sprinkle_ticks;
      int cap;
      cap = (limit_ticks < 8) ? 1 : ((limit_ticks / 4 > 20) ? 20 : int'(limit_ticks / 4));
      if ($urandom_range(0, 7) == 0) push_ticks($urandom_range(1, cap));
   endtask

   task push_frame(input logic [7:0] iface, input logic [7:0] len, input bit good,
                   input bit with_ticks);
      logic [7:0] acc;
      logic [7:0] b;
      acc = iface + len;
      push_byte(iface);
      if (with_ticks) sprinkle_ticks();
      push_byte(len);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         acc = acc + b;
         if (with_ticks) sprinkle_ticks();
         push_byte(b);
      end
      if (with_ticks) sprinkle_ticks();
      push_byte(good ? acc : acc ^ 8'($urandom_range(1, 255)));
   endtask

   task random_traffic(input int n);
      int start;
      int r;
      logic [7:0] len;
      start = n_queued;
      while (n_queued - start < n) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 40)) :
                                                8'($urandom_range(0, 6));
            push_frame(8'($urandom), len, $urandom_range(0, 7) != 0, 1'b1);
         end else if (r < 83) begin
            push_ticks($urandom_range(1, 3));
         end else if (r < 88 && limit_ticks <= 300) begin
            push_ticks((limit_ticks == 0) ? 1 : int'(limit_ticks));
         end else if (r < 94) begin
            push_byte(8'($urandom));
            if ($urandom_range(0, 1)) begin
               push_byte(8'($urandom_range(0, 12)));
               for (int i = $urandom_range(0, 2); i > 0; i--) push_byte(8'($urandom));
            end
         end else begin
            for (int i = $urandom_range(1, 3); i > 0; i--) push_byte(8'($urandom));
         end
      end
   endtask

   task wait_drained;
      @(negedge clock);
      while (tx_items.size() != 0 || n_accepted != n_queued || frame_results_q.size() != 0)
         @(negedge clock);
   endtask

   task write_limit(input logic [lpr_pkg::TIMEOUT_WIDTH-1:0] v);
      wait_drained();
      repeat (8) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      limit_ticks = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // limit after reset
      push_frame(8'hFF, 8'd0, 1'b1, 1'b0);
      push_byte(8'h00);
      push_byte(8'h02);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'h01);
      push_frame(8'h5A, 8'd1, 1'b0, 1'b0);
      push_byte(8'h81);
      push_ticks(40);
      push_frame(8'($urandom), 8'd255, 1'b1, 1'b0);
      random_traffic(60);

      write_limit(16'd2);
      push_ticks(2);
      push_byte(8'hA5);
      push_ticks(2);
      push_byte(8'h11);
      push_byte(8'd1);
      push_ticks(2);
      push_byte(8'h22);
      push_byte(8'd0);
      push_ticks(2);
      random_traffic(80);

      write_limit(16'd0);
      push_ticks(1);
      push_byte(8'h3C);
      push_ticks(1);
      random_traffic(50);

      write_limit(16'd1);
      random_traffic(50);

      write_limit(16'hFFFF);
      push_byte(8'h77);
      push_byte(8'd3);
      push_byte(8'h80);
      push_ticks(5);
      random_traffic(50);

      write_limit(16'($urandom_range(3, 64)));
      push_byte(8'h42);
      push_byte(8'd5);
      push_byte(8'($urandom));
      push_byte(8'($urandom));
      wait_drained();
      push_byte(8'($urandom));
      push_byte(8'($urandom));
      push_byte(8'($urandom));
      push_byte(8'($urandom));
      random_traffic(80);

      write_limit(16'($urandom_range(24, 60)));
      random_traffic(70);

      write_limit(16'($urandom_range(3, 20)));
      random_traffic(70);

      write_limit(16'd1000);
      random_traffic(60);

      wait_drained();
      repeat (10) @(negedge clock);
      if (n_errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
